// File: hw/rtl/motor_fault_supervisor_defines.svh
// Assertion macros shared by the motor fault supervisor RTL.
// Each macro expects signals named clk and rst_n in the using scope.
// No other dependencies.
`ifndef MOTOR_FAULT_SUPERVISOR_DEFINES_SVH
`define MOTOR_FAULT_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfs assertion failed");
// Next-cycle implication, checked outside reset.
`define MFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfs assertion failed");
`else
`define MFS_ASSERT_IMP(label, ante, cons)
`define MFS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/mfs_pkg.sv
// Package for the motor fault supervisor: types, constants and register codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

  localparam logic [7:0]  WINDOW_LEN       = 8'd250;
  localparam logic [4:0]  TEMP_DEBOUNCE    = 5'd30;
  localparam logic [4:0]  TEMP_TRIPPED     = 5'd31;
  localparam logic [7:0]  CURRENT_DEBOUNCE = 8'd150;
  localparam logic [7:0]  CURRENT_TRIPPED  = 8'd151;
  localparam logic [15:0] STALL_SPEED      = 16'd200;
  localparam logic [14:0] CURRENT_CAP      = 15'd16384;
  localparam logic [1:0]  RETRY_MAX        = 2'd3;

  localparam int BIT_STALL        = 0;
  localparam int BIT_OVER_CURRENT = 1;
  localparam int BIT_OVER_TEMP    = 2;
  localparam int BIT_ALERT        = 3;
  localparam int BIT_FLASH        = 4;
  localparam int BIT_CALIB        = 5;
  localparam int BIT_ENCODER      = 6;

  localparam logic [15:0] OVER_TEMP_RESET    = 16'd85;
  localparam logic [15:0] ALERT_TEMP_RESET   = 16'd75;
  localparam logic [14:0] OVER_CURRENT_RESET = 15'd16384;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_CLEAR = 1'b1
  } mfs_func_t;

  typedef enum logic [1:0] {
    CFG_OVER_TEMP    = 2'd0,
    CFG_ALERT_TEMP   = 2'd1,
    CFG_OVER_CURRENT = 2'd2
  } mfs_cfg_idx_t;

  typedef struct packed {
    mfs_func_t          func;
    logic signed [15:0] temperature;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic               flash_fault;
    logic               calib_fault;
    logic               encoder_fault;
  } mfs_item_t;

  typedef struct packed {
    logic signed [15:0] over_temp_limit;
    logic signed [15:0] alert_temp_limit;
    logic [14:0]        over_current_limit;
  } mfs_cfg_t;

  typedef struct packed {
    logic [6:0] error_flags;
    logic [1:0] retry_events;
  } mfs_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfs_in_stage.sv
// Input register of the motor fault supervisor: holds one beat for the core.
// Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_in_stage
  import mfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mfs_item_t in_item,
  input  wire logic      advance,
  output logic           item_valid,
  output mfs_item_t      item
);

  logic      valid_r, valid_nxt;
  mfs_item_t item_r;
  logic      load;

  // The held beat leaves whenever the result side can take it.
  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/mfs_core.sv
// Fault supervisor core: debounce counters, retry window and error word.
// Depends on mfs_pkg and motor_fault_supervisor_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "motor_fault_supervisor_defines.svh"

module mfs_core
  import mfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      take,
  input  wire mfs_item_t item,
  input  wire mfs_cfg_t  cfg,
  output mfs_result_t    result
);

  logic [7:0]         win_r, win_nxt;
  logic [6:0]         err_r, err_nxt;
  logic [1:0]         rc_r, rc_nxt;
  logic signed [16:0] hyst_r, hyst_nxt;
  logic [4:0]         ot_cnt_r, ot_cnt_nxt;
  logic [4:0]         al_cnt_r, al_cnt_nxt;
  logic [7:0]         oc_cnt_r, oc_cnt_nxt;

  logic [8:0]         win_inc;
  logic               expire;
  logic [6:0]         err_kept;
  logic [1:0]         rc_bump;
  logic signed [15:0] alert;
  logic signed [17:0] ot_thr;
  logic signed [17:0] temp_ext;
  logic [14:0]        climit;
  logic [15:0]        cur_mag;
  logic [15:0]        spd_mag;
  logic               trip;

  always_comb begin
    win_inc  = {1'b0, win_r} + 9'd1;
    expire   = win_inc > {1'b0, WINDOW_LEN};
    alert    = (cfg.alert_temp_limit > cfg.over_temp_limit) ?
               cfg.over_temp_limit : cfg.alert_temp_limit;
    ot_thr   = {{2{cfg.over_temp_limit[15]}}, cfg.over_temp_limit} +
               {hyst_r[16], hyst_r};
    temp_ext = {{2{item.temperature[15]}}, item.temperature};
    climit   = (cfg.over_current_limit > CURRENT_CAP) ? CURRENT_CAP : cfg.over_current_limit;
    // The most negative code comes out as 32768, which still fits unsigned.
    cur_mag  = item.current[15] ? (~item.current + 16'd1) : item.current;
    spd_mag  = item.speed[15] ? (~item.speed + 16'd1) : item.speed;
    rc_bump  = (rc_r < RETRY_MAX) ? rc_r + 2'd1 : rc_r;

    win_nxt    = win_r;
    err_nxt    = err_r;
    rc_nxt     = rc_r;
    hyst_nxt   = hyst_r;
    ot_cnt_nxt = ot_cnt_r;
    al_cnt_nxt = al_cnt_r;
    oc_cnt_nxt = oc_cnt_r;
    err_kept   = err_r;
    trip       = 1'b0;

    if (item.func == FUNC_CLEAR) begin
      err_nxt = '0;
      rc_nxt  = '0;
    end else begin
      // Window expiry is evaluated before this tick's faults latch.
      win_nxt = expire ? 8'd0 : win_inc[7:0];
      if (expire) begin
        err_kept = err_r & 7'b0000011;
        if (err_kept != 7'd0) begin
          rc_nxt = rc_bump;
          if (rc_bump < RETRY_MAX) begin
            err_kept = '0;
          end
        end
      end
      err_nxt = err_kept;
      if (item.flash_fault) begin
        err_nxt[BIT_FLASH] = 1'b1;
      end
      if (item.calib_fault) begin
        err_nxt[BIT_CALIB] = 1'b1;
      end
      if (item.encoder_fault) begin
        err_nxt[BIT_ENCODER] = 1'b1;
      end

      if (temp_ext > ot_thr) begin
        if (ot_cnt_r < TEMP_DEBOUNCE) begin
          ot_cnt_nxt = ot_cnt_r + 5'd1;
        end else begin
          ot_cnt_nxt = TEMP_TRIPPED;
          hyst_nxt   = {alert[15], alert} - {cfg.over_temp_limit[15], cfg.over_temp_limit};
          err_nxt[BIT_OVER_TEMP] = 1'b1;
          trip       = 1'b1;
        end
      end else begin
        hyst_nxt   = '0;
        ot_cnt_nxt = '0;
      end

      if (item.temperature > alert) begin
        if (al_cnt_r < TEMP_DEBOUNCE) begin
          al_cnt_nxt = al_cnt_r + 5'd1;
        end else begin
          al_cnt_nxt = TEMP_TRIPPED;
          err_nxt[BIT_ALERT] = 1'b1;
          trip       = 1'b1;
        end
      end else begin
        al_cnt_nxt = '0;
      end

      if (cur_mag > {1'b0, climit}) begin
        if (oc_cnt_r < CURRENT_DEBOUNCE) begin
          oc_cnt_nxt = oc_cnt_r + 8'd1;
        end else begin
          oc_cnt_nxt = CURRENT_TRIPPED;
          trip       = 1'b1;
          if (spd_mag < STALL_SPEED) begin
            err_nxt[BIT_STALL] = 1'b1;
          end
          err_nxt[BIT_OVER_CURRENT] = 1'b1;
        end
      end else begin
        oc_cnt_nxt = '0;
      end

      // Any active trip restarts the retry window.
      if (trip) begin
        win_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      err_r    <= '0;
      rc_r     <= '0;
      hyst_r   <= '0;
      ot_cnt_r <= '0;
      al_cnt_r <= '0;
      oc_cnt_r <= '0;
    end else if (take) begin
      win_r    <= win_nxt;
      err_r    <= err_nxt;
      rc_r     <= rc_nxt;
      hyst_r   <= hyst_nxt;
      ot_cnt_r <= ot_cnt_nxt;
      al_cnt_r <= al_cnt_nxt;
      oc_cnt_r <= oc_cnt_nxt;
    end
  end

  assign result.error_flags  = err_nxt;
  assign result.retry_events = rc_nxt;

  `MFS_ASSERT_IMP(a_window_bound, 1'b1, win_r <= WINDOW_LEN)
  `MFS_ASSERT_IMP(a_stall_needs_oc, err_r[BIT_STALL], err_r[BIT_OVER_CURRENT])
  `MFS_ASSERT_IMP(a_hyst_when_tripped, hyst_r != 17'sd0, ot_cnt_r == TEMP_TRIPPED)
  `MFS_ASSERT_NXT(a_clear_zeroes, take && item.func == FUNC_CLEAR, err_r == 7'd0 && rc_r == 2'd0)

endmodule

`default_nettype wire

// File: hw/rtl/motor_fault_supervisor.sv
// Motor fault supervisor top level: ports, configuration registers, result register.
// Depends on mfs_pkg, mfs_in_stage and mfs_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one tick per clock unless out_tready stalls the result side, and gives one
// result beat per tick: the beat is captured in an input register, the single-pass
// core updates its debounce counters and error word from it, and the result lands
// in an output register. The input side keeps accepting while a result waits, as
// long as the output register frees up in the same cycle. The cfg port is always
// ready; write it only while no ticks are in flight. Register index 3 is ignored.
module motor_fault_supervisor
  import mfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: temperature[15:0], current[31:16], speed[47:32], flash_fault[48],
  // calib_fault[49], encoder_fault[50], zero pad[55:51].
  input  wire logic [55:0] in_tdata,
  // tuser: func[0].
  input  wire logic        in_tuser,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: error_flags[6:0], retry_events[8:7], zero pad[15:9].
  output logic [15:0]      out_tdata,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  mfs_item_t   in_item;
  mfs_item_t   item;
  logic        item_valid;
  logic        out_free;
  logic        take;
  mfs_cfg_t    cfg_r;
  mfs_result_t result;
  mfs_result_t res_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_item.func          = mfs_func_t'(in_tuser);
  assign in_item.temperature   = in_tdata[15:0];
  assign in_item.current       = in_tdata[31:16];
  assign in_item.speed         = in_tdata[47:32];
  assign in_item.flash_fault   = in_tdata[48];
  assign in_item.calib_fault   = in_tdata[49];
  assign in_item.encoder_fault = in_tdata[50];

  assign out_free = !out_valid_r || out_tready;
  assign take     = item_valid && out_free;

  mfs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  mfs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_temp_limit    <= OVER_TEMP_RESET;
      cfg_r.alert_temp_limit   <= ALERT_TEMP_RESET;
      cfg_r.over_current_limit <= OVER_CURRENT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OVER_TEMP:    cfg_r.over_temp_limit    <= cfg_data;
        CFG_ALERT_TEMP:   cfg_r.alert_temp_limit   <= cfg_data;
        CFG_OVER_CURRENT: cfg_r.over_current_limit <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.retry_events, res_r.error_flags};

endmodule

`default_nettype wire

// File: tb/mfs_checker.sv
`timescale 1ns / 1ps
// Result checker for the motor fault supervisor. It follows the cfg writes, works out
// the expected error word and retry count for each accepted tick, and checks every
// result beat against them. Depends on mfs_pkg.

module mfs_checker
  import mfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  logic signed [15:0] hot_limit;
  logic signed [15:0] alert_limit;
  logic [14:0]        amp_limit;

  logic [7:0]         window_cnt;
  logic [6:0]         fault_word;
  logic [1:0]         retries;
  logic signed [16:0] release_offset;
  logic [4:0]         hot_cnt;
  logic [4:0]         alert_cnt;
  logic [7:0]         amp_cnt;

  mfs_result_t expected_faults[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advances the supervisor state by one beat and queues the result it gives.
  task automatic update_fault_word(input mfs_item_t it);
    int hot;
    int alert;
    int amp_cap;
    int temp;
    int rel;
    int cur;
    int spd;
    mfs_result_t res;
    if (it.func == FUNC_CLEAR) begin
      fault_word = '0;
      retries    = '0;
    end else begin
      // Window expiry is handled before this tick's faults are latched.
      if (window_cnt >= WINDOW_LEN) begin
        window_cnt = '0;
        fault_word = fault_word & ((7'd1 << BIT_STALL) | (7'd1 << BIT_OVER_CURRENT));
        if (fault_word != '0) begin
          if (retries < RETRY_MAX) retries = retries + 2'd1;
          if (retries < RETRY_MAX) fault_word = '0;
        end
      end else begin
        window_cnt = window_cnt + 8'd1;
      end

      if (it.flash_fault) fault_word[BIT_FLASH] = 1'b1;
      if (it.calib_fault) fault_word[BIT_CALIB] = 1'b1;
      if (it.encoder_fault) fault_word[BIT_ENCODER] = 1'b1;

      hot   = int'(hot_limit);
      alert = (alert_limit > hot_limit) ? hot : int'(alert_limit);
      temp  = int'(it.temperature);
      rel   = int'(release_offset);

      if (temp > hot + rel) begin
        if (hot_cnt < TEMP_DEBOUNCE) begin
          hot_cnt = hot_cnt + 5'd1;
        end else begin
          hot_cnt        = TEMP_TRIPPED;
          release_offset = 17'(alert - hot);
          fault_word[BIT_OVER_TEMP] = 1'b1;
          window_cnt     = '0;
        end
      end else begin
        release_offset = '0;
        hot_cnt        = '0;
      end

      if (temp > alert) begin
        if (alert_cnt < TEMP_DEBOUNCE) begin
          alert_cnt = alert_cnt + 5'd1;
        end else begin
          alert_cnt = TEMP_TRIPPED;
          fault_word[BIT_ALERT] = 1'b1;
          window_cnt = '0;
        end
      end else begin
        alert_cnt = '0;
      end

      amp_cap = int'((amp_limit > CURRENT_CAP) ? CURRENT_CAP : amp_limit);
      cur = int'(it.current);
      spd = int'(it.speed);
      if (cur < 0) cur = -cur;
      if (spd < 0) spd = -spd;
      if (cur > amp_cap) begin
        if (amp_cnt < CURRENT_DEBOUNCE) begin
          amp_cnt = amp_cnt + 8'd1;
        end else begin
          amp_cnt    = CURRENT_TRIPPED;
          window_cnt = '0;
          if (spd < int'(STALL_SPEED)) fault_word[BIT_STALL] = 1'b1;
          fault_word[BIT_OVER_CURRENT] = 1'b1;
        end
      end else begin
        amp_cnt = '0;
      end
    end
    res.error_flags  = fault_word;
    res.retry_events = retries;
    expected_faults.push_back(res);
  endtask

  always @(posedge clk) begin : monitor
    mfs_item_t   it;
    mfs_result_t got;
    mfs_result_t want;
    if (!rst_n) begin
      hot_limit      = OVER_TEMP_RESET;
      alert_limit    = ALERT_TEMP_RESET;
      amp_limit      = OVER_CURRENT_RESET;
      window_cnt     = '0;
      fault_word     = '0;
      retries        = '0;
      release_offset = '0;
      hot_cnt        = '0;
      alert_cnt      = '0;
      amp_cnt        = '0;
      expected_faults.delete();
      mismatches     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OVER_TEMP:    hot_limit = cfg_data;
          CFG_ALERT_TEMP:   alert_limit = cfg_data;
          CFG_OVER_CURRENT: amp_limit = cfg_data[14:0];
          default: ;
        endcase
      end

      // A result beat always comes from an earlier tick, so check it before queueing a new one.
      if (out_tvalid && out_tready) begin
        got.error_flags  = out_tdata[6:0];
        got.retry_events = out_tdata[8:7];
        if (expected_faults.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no tick outstanding", out_tdata));
        end else begin
          want = expected_faults.pop_front();
          if (got.error_flags !== want.error_flags)
            report_mismatch($sformatf("error_flags %b, expected %b",
                                      got.error_flags, want.error_flags));
          if (got.retry_events !== want.retry_events)
            report_mismatch($sformatf("retry_events %0d, expected %0d",
                                      got.retry_events, want.retry_events));
        end
      end

      if (in_tvalid && in_tready) begin
        it.func          = mfs_func_t'(in_tuser);
        it.temperature   = in_tdata[15:0];
        it.current       = in_tdata[31:16];
        it.speed         = in_tdata[47:32];
        it.flash_fault   = in_tdata[48];
        it.calib_fault   = in_tdata[49];
        it.encoder_fault = in_tdata[50];
        update_fault_word(it);
      end
    end
    outstanding = expected_faults.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the motor fault supervisor testbench: clock, reset, tick and cfg stimulus,
// result back-pressure, watchdog and verdict. Depends on mfs_pkg, mfs_checker and the RTL.

module testbench;
  import mfs_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Kinds of tick runs used to walk the debounce counters and the window.
  localparam int SEG_CALM  = 0;
  localparam int SEG_STALL = 1;
  localparam int SEG_SPIN  = 2;
  localparam int SEG_HOT   = 3;
  localparam int SEG_WARM  = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  // Limits as last written, used only to aim the stimulus around the thresholds.
  int hot_lim = 85;
  int alert_lim = 75;
  int amp_lim = 16384;

  motor_fault_supervisor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mfs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Applies a random sign to a magnitude of up to 32768.
  function automatic int with_sign(input int m);
    if (m >= 32768) return -32768;
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic int cold_temp();
    int ta;
    ta = (alert_lim > hot_lim) ? hot_lim : alert_lim;
    return rand_between((ta < -32468) ? -32768 : ta - 300, ta);
  endfunction

  // Above the alert level but not above the trip limit: the hysteresis band; a cold value if that band is empty.
  function automatic int warm_temp();
    int ta;
    ta = (alert_lim > hot_lim) ? hot_lim : alert_lim;
    if (ta < hot_lim) return rand_between(ta + 1, hot_lim);
    return cold_temp();
  endfunction

  function automatic int low_amps();
    int cap;
    cap = (amp_lim > int'(CURRENT_CAP)) ? int'(CURRENT_CAP) : amp_lim;
    return with_sign(rand_between(0, cap));
  endfunction

  function automatic int high_amps();
    int cap;
    cap = (amp_lim > int'(CURRENT_CAP)) ? int'(CURRENT_CAP) : amp_lim;
    return with_sign(rand_between(cap + 1, 32768));
  endfunction

  task automatic send_tick(input mfs_func_t fn, input int t, input int c, input int s,
                           input logic ff, input logic cf, input logic ef);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'd0, ef, cf, ff, 16'(s), 16'(c), 16'(t)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OVER_TEMP:    hot_lim = value;
      CFG_ALERT_TEMP:   alert_lim = value;
      CFG_OVER_CURRENT: amp_lim = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Lets every tick in flight come back before the limits change.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Alternates calm stretches with runs that hold a fault; lengths are drawn so that some
  // calm stretches outlast the window and some runs trip their debounce counter.
  task automatic random_ticks(input int count);
    int left;
    int kind;
    int len;
    int k;
    int t;
    int c;
    int s;
    int roll;
    logic ff;
    logic cf;
    logic ef;
    mfs_func_t fn;
    bit busy;
    left = count;
    busy = 1'b0;
    while (left > 0) begin
      if (busy) begin
        kind = $urandom_range(SEG_STALL, SEG_WARM);
      end else begin
        kind = SEG_CALM;
      end
      busy = !busy;
      case (kind)
        SEG_CALM:  len = rand_between(100, 300);
        SEG_HOT:   len = rand_between(25, 60);
        SEG_WARM:  len = rand_between(10, 40);
        default:   len = rand_between(140, 175);
      endcase
      for (k = 0; k < len && left > 0; k++) begin
        fn   = FUNC_TICK;
        ff   = ($urandom_range(0, 59) == 0);
        cf   = ($urandom_range(0, 59) == 0);
        ef   = ($urandom_range(0, 59) == 0);
        t    = cold_temp();
        c    = low_amps();
        s    = rand_between(-32768, 32767);
        roll = $urandom_range(0, 99);
        case (kind)
          SEG_CALM: begin
            if (roll < 6) begin
              t  = rand_between(-32768, 32767);
              c  = rand_between(-32768, 32767);
              ff = 1'($urandom_range(0, 1));
              cf = 1'($urandom_range(0, 1));
              ef = 1'($urandom_range(0, 1));
            end
          end
          SEG_STALL: begin
            c = high_amps();
            s = with_sign(rand_between(0, int'(STALL_SPEED) - 1));
          end
          SEG_SPIN: begin
            c = high_amps();
            s = with_sign(rand_between(int'(STALL_SPEED), 32768));
          end
          SEG_HOT: begin
            // The tail of a hot run cools into the band between alert and limit.
            if (k < len - 8 && hot_lim < 32767)
              t = rand_between(hot_lim + 1, (hot_lim > 32467) ? 32767 : hot_lim + 300);
            else
              t = warm_temp();
            if (roll < 2) fn = FUNC_CLEAR;
          end
          SEG_WARM: begin
            t = warm_temp();
            if (roll < 2) fn = FUNC_CLEAR;
          end
          default: ;
        endcase
        send_tick(fn, t, c, s, ff, cf, ef);
        left--;
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_OVER_TEMP, 85);
    write_reg(CFG_ALERT_TEMP, 75);
    write_reg(CFG_OVER_CURRENT, 16384);

    // Field extremes, the thresholds on both sides, external flags and clears.
    send_tick(FUNC_CLEAR, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 20, 100, 1000, 1'b1, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 20, -100, -1000, 1'b0, 1'b1, 1'b1);
    send_tick(FUNC_TICK, 32767, -32768, -32768, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, -32768, 32767, 32767, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 85, 16384, 199, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 86, 16385, 200, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 75, -16384, -199, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_TICK, 76, -16385, -200, 1'b0, 1'b0, 1'b0);
    send_tick(FUNC_CLEAR, 32767, -32768, -32768, 1'b1, 1'b1, 1'b1);
    send_tick(FUNC_TICK, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    settle();

    // Lowest trip limit, alert above it, zero current threshold, spare index.
    write_reg(CFG_OVER_TEMP, -32768);
    write_reg(CFG_ALERT_TEMP, 32767);
    write_reg(CFG_OVER_CURRENT, 0);
    write_reg(CFG_SPARE, 16'h5a5a);
    gap_pct   = 0;
    stall_pct = 0;
    random_ticks(360);
    settle();

    write_reg(CFG_OVER_TEMP, 32767);
    write_reg(CFG_ALERT_TEMP, -32768);
    write_reg(CFG_OVER_CURRENT, 32767);
    gap_pct = 66;
    random_ticks(360);
    settle();

    write_reg(CFG_OVER_TEMP, 40);
    write_reg(CFG_ALERT_TEMP, 25);
    write_reg(CFG_OVER_CURRENT, 3000);
    gap_pct   = 0;
    stall_pct = 66;
    random_ticks(360);
    settle();

    write_reg(CFG_OVER_TEMP, 60);
    write_reg(CFG_ALERT_TEMP, 70);
    write_reg(CFG_OVER_CURRENT, 16385);
    gap_pct   = 33;
    stall_pct = 33;
    random_ticks(360);
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
